// File: sv/bounded_linked_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Bounded linked list engine: assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define BLLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded_linked_list_engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BLLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded_linked_list_engine: next-cycle check failed");

`else

`define BLLE_ASSERT_NOW(label, clk, rst, ante, cons)
`define BLLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/blle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded linked list engine package
// Operation and status codes, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package blle_pkg;

   localparam int DEF_CAPACITY = 16;

   // Operation codes carried on req_mode.
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_INSERT     = 3'd4;
   localparam logic [2:0] MODE_DUMP       = 3'd5;

   // Status codes carried on rsp_status.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_WALK_ISSUE,
      ST_WALK,
      ST_FINISH,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_POP_WAIT,
      ST_DUMP
   } state_type;

endpackage

// File: sv/bounded_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded linked list engine
// Pop front needs no scan; pushes and inserts first scan for the lowest free slot;
// pop back and a mid-list insert also walk the links from the head.
// Dump streams one element per cycle, head to tail.
// One operation at a time, set by the free-slot scan and the link RAM port.
// Synchronous reset empties the list at once; the RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_linked_list_engine_defines.svh"

module bounded_linked_list_engine
   import blle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   // Command side: a transfer happens when start is high and busy is low.
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   // Result side: one transfer per cycle in which rsp_strobe is high.
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value_res,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   // Slot index width, element count width and the width used to compare
   // an insert position against the count.
   localparam int SW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   // ------------------------------------------------------------------------
   // List state. Head and tail mean nothing while the count is zero.
   // ------------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [SW-1:0]           head_ff, head_in;
   logic [SW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CAPACITY-1:0]     free_ff, free_in;

   // Per-operation working registers.
   logic [2:0]              op_ff, op_in;
   logic signed [31:0]      val_ff, val_in;
   logic [7:0]              pos_ff, pos_in;
   logic [SW-1:0]           slot_ff, slot_in;   // newly taken slot
   logic [SW-1:0]           prev_ff, prev_in;   // end point of a link walk
   logic [SW-1:0]           scan_ff, scan_in;   // free-slot scan index
   logic [CW-1:0]           left_ff, left_in;   // links or elements still to go

   // Result register: the strobe is control, the rest is payload.
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic signed [31:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // RAM ports.
   logic                    data_we, data_re;
   logic [SW-1:0]           data_wa, data_ra;
   logic [31:0]             data_wd, data_rd;
   logic                    link_we, link_re;
   logic [SW-1:0]           link_wa, link_ra;
   logic [SW-1:0]           link_wd, link_rd;

   logic                    list_empty;
   logic                    list_full;
   logic                    count_above_one;

   assign list_empty      = (count_ff == '0);
   assign list_full       = (count_ff == CW'(CAPACITY));
   assign count_above_one = (count_ff > CW'(1));

   // ------------------------------------------------------------------------
   // Element values and next-slot links live in two RAMs of CAPACITY words.
   // Every slot on the list has been written before it is read, so neither
   // RAM needs clearing.
   // ------------------------------------------------------------------------
   blle_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wa),
      .wr_data (data_wd),
      .rd_en   (data_re),
      .rd_addr (data_ra),
      .rd_data (data_rd)
   );

   blle_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // ------------------------------------------------------------------------
   // Sequencer. The operation is decoded in the cycle after the transfer. The
   // scan and the walk step with separate counters: the scan steps through the
   // free mask one slot per cycle to find the lowest free slot, and the walk
   // follows one link per cycle, feeding the registered link RAM output
   // straight back as the next read address.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      scan_in       = scan_ff;
      left_in       = left_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      data_we       = 1'b0;
      data_wa       = slot_ff;
      data_wd       = val_ff;
      data_re       = 1'b0;
      data_ra       = head_ff;
      link_we       = 1'b0;
      link_wa       = slot_ff;
      link_wd       = '0;
      link_re       = 1'b0;
      link_ra       = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_mode;
               val_in   = req_value;
               pos_in   = req_position;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            case (op_ff)
               MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                  if (list_full) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_FULL;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end

               MODE_INSERT: begin
                  // The position check comes before the fullness check.
                  if (CMPW'(pos_ff) > CMPW'(count_ff)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_BADPOS;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else if (list_full) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_FULL;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     // Inserts at either end become plain pushes.
                     if (pos_ff == '0) begin
                        op_in = MODE_PUSH_FRONT;
                     end else if (CMPW'(pos_ff) == CMPW'(count_ff)) begin
                        op_in = MODE_PUSH_BACK;
                     end else begin
                        left_in = CW'(pos_ff) - CW'(1);
                     end
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end

               MODE_POP_FRONT: begin
                  if (list_empty) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     data_re  = 1'b1;
                     data_ra  = head_ff;
                     link_re  = 1'b1;
                     link_ra  = head_ff;
                     state_in = ST_POP_WAIT;
                  end
               end

               MODE_POP_BACK: begin
                  if (list_empty) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     // The tail value is held in the data RAM output while
                     // the walk finds the element before the tail.
                     data_re = 1'b1;
                     data_ra = tail_ff;
                     if (count_above_one) begin
                        left_in  = count_ff - CW'(2);
                        state_in = ST_WALK_ISSUE;
                     end else begin
                        state_in = ST_POP_WAIT;
                     end
                  end
               end

               MODE_DUMP: begin
                  if (list_empty) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     data_re  = 1'b1;
                     data_ra  = head_ff;
                     link_re  = 1'b1;
                     link_ra  = head_ff;
                     left_in  = count_ff;
                     state_in = ST_DUMP;
                  end
               end

               default: begin
                  // Unused codes are dropped without a result.
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            if (free_ff[scan_ff]) begin
               slot_in  = scan_ff;
               state_in = (op_ff == MODE_INSERT) ? ST_WALK_ISSUE : ST_WRITE_A;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end

         ST_WALK_ISSUE: begin
            if (left_ff == '0) begin
               prev_in  = head_ff;
               state_in = ST_FINISH;
            end else begin
               link_re  = 1'b1;
               link_ra  = head_ff;
               left_in  = left_ff - CW'(1);
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            if (left_ff == '0) begin
               prev_in  = link_rd;
               state_in = ST_FINISH;
            end else begin
               link_re = 1'b1;
               link_ra = link_rd;
               left_in = left_ff - CW'(1);
            end
         end

         ST_FINISH: begin
            if (op_ff == MODE_POP_BACK) begin
               // Cut the list after the element before the old tail.
               link_we          = 1'b1;
               link_wa          = prev_ff;
               link_wd          = '0;
               tail_in          = prev_ff;
               free_in[tail_ff] = 1'b1;
               count_in         = count_ff - CW'(1);
               rsp_strobe_in    = 1'b1;
               rsp_value_in     = data_rd;
               rsp_status_in    = STATUS_OK;
               rsp_last_in      = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               // Fetch the successor of the insert point.
               link_re  = 1'b1;
               link_ra  = prev_ff;
               state_in = ST_WRITE_A;
            end
         end

         ST_WRITE_A: begin
            data_we = 1'b1;
            link_we = 1'b1;
            case (op_ff)
               MODE_PUSH_FRONT: begin
                  link_wd          = list_empty ? '0 : head_ff;
                  head_in          = slot_ff;
                  if (list_empty) begin
                     tail_in = slot_ff;
                  end
                  count_in         = count_ff + CW'(1);
                  free_in[slot_ff] = 1'b0;
                  rsp_strobe_in    = 1'b1;
                  rsp_value_in     = val_ff;
                  rsp_status_in    = STATUS_OK;
                  rsp_last_in      = 1'b1;
                  state_in         = ST_IDLE;
               end

               MODE_PUSH_BACK: begin
                  link_wd = '0;
                  if (list_empty) begin
                     head_in          = slot_ff;
                     tail_in          = slot_ff;
                     count_in         = count_ff + CW'(1);
                     free_in[slot_ff] = 1'b0;
                     rsp_strobe_in    = 1'b1;
                     rsp_value_in     = val_ff;
                     rsp_status_in    = STATUS_OK;
                     rsp_last_in      = 1'b1;
                     state_in         = ST_IDLE;
                  end else begin
                     state_in = ST_WRITE_B;
                  end
               end

               default: begin
                  // Insert in the middle: the new slot takes over the link
                  // of the insert point.
                  link_wd  = link_rd;
                  state_in = ST_WRITE_B;
               end
            endcase
         end

         ST_WRITE_B: begin
            link_we = 1'b1;
            link_wd = slot_ff;
            if (op_ff == MODE_PUSH_BACK) begin
               link_wa = tail_ff;
               tail_in = slot_ff;
            end else begin
               link_wa = prev_ff;
            end
            count_in         = count_ff + CW'(1);
            free_in[slot_ff] = 1'b0;
            rsp_strobe_in    = 1'b1;
            rsp_value_in     = val_ff;
            rsp_status_in    = STATUS_OK;
            rsp_last_in      = 1'b1;
            state_in         = ST_IDLE;
         end

         ST_POP_WAIT: begin
            if (op_ff == MODE_POP_FRONT) begin
               if (count_above_one) begin
                  head_in = link_rd;
               end
               free_in[head_ff] = 1'b1;
            end else begin
               // Pop back of the only element.
               free_in[tail_ff] = 1'b1;
            end
            count_in      = count_ff - CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_value_in  = data_rd;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DUMP: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = data_rd;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = (left_ff == CW'(1));
            if (left_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               data_re = 1'b1;
               data_ra = link_rd;
               link_re = 1'b1;
               link_ra = link_rd;
               left_in = left_ff - CW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         free_ff       <= '1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      scan_ff       <= scan_in;
      left_ff       <= left_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Every slot is either on the list or free, never both.
   `BLLE_ASSERT_NOW(a_slot_accounting, clock, reset, 1'b1,
                    ($countones(free_ff) + int'(count_ff)) == CAPACITY)
   // A result always comes from work done in the cycle before.
   `BLLE_ASSERT_NOW(a_result_from_work, clock, reset, rsp_strobe, $past(busy))
   // A failed operation gives one final result with a zero value.
   `BLLE_ASSERT_NOW(a_fail_is_final, clock, reset, rsp_strobe && (rsp_status != STATUS_OK),
                    rsp_last && (rsp_value_res == '0))
   // Dump results follow one another without a gap until the last one.
   `BLLE_ASSERT_NEXT(a_dump_streams, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)

endmodule

// File: sv/blle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module blle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read word holds until the next enabled read.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/blle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded linked list engine: result checker
// Watches both channels, keeps its own copy of the list and compares every
// result transfer with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module blle_checker
   import blle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   input  logic               rsp_strobe,
   input  logic signed [31:0] rsp_value_res,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 outstanding,
   output int                 list_length,
   output int                 ops_accepted,
   output int                 results_checked,
   output int                 peak_length,
   output int                 full_hits,
   output int                 empty_hits,
   output int                 badpos_hits
);

   localparam int SLOT_W = $clog2(CAPACITY);

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               last;
   } list_answer_type;

   list_answer_type    answers [$];

   // Shadow copy of the list.
   logic signed [31:0] slot_value [CAPACITY];
   slot_type           slot_link  [CAPACITY];
   slot_type           head;
   slot_type           tail;
   int                 entry_count;
   logic [CAPACITY-1:0] free_slots;

   int mismatches;
   int accepted;
   int checked;
   int peak;
   int n_full;
   int n_empty;
   int n_badpos;

   function automatic void queue_answer(logic signed [31:0] value, logic [1:0] status,
                                        logic last);
      list_answer_type a;
      a.value  = value;
      a.status = status;
      a.last   = last;
      answers.insert(answers.size(), a);
      if (status == STATUS_FULL) n_full++;
      if (status == STATUS_EMPTY) n_empty++;
      if (status == STATUS_BADPOS) n_badpos++;
   endfunction

   // The lowest free slot is always the one handed out.
   function automatic slot_type claim_slot();
      for (int i = 0; i < CAPACITY; i++) begin
         if (free_slots[i]) begin
            free_slots[i] = 1'b0;
            return slot_type'(i);
         end
      end
      return '0;
   endfunction

   function automatic slot_type walk_links(int hops);
      slot_type s;
      s = head;
      for (int i = 0; i < hops && i < CAPACITY; i++) s = slot_link[s];
      return s;
   endfunction

   function automatic void link_front(logic signed [31:0] v);
      slot_type s;
      s = claim_slot();
      slot_value[s] = v;
      if (entry_count == 0) begin
         slot_link[s] = '0;
         tail = s;
      end else begin
         slot_link[s] = head;
      end
      head = s;
      entry_count++;
   endfunction

   function automatic void link_back(logic signed [31:0] v);
      slot_type s;
      s = claim_slot();
      slot_value[s] = v;
      slot_link[s] = '0;
      if (entry_count == 0) head = s;
      else slot_link[tail] = s;
      tail = s;
      entry_count++;
   endfunction

   function automatic void apply_operation(logic [2:0] mode, logic signed [31:0] v,
                                           logic [7:0] pos);
      slot_type s;
      slot_type prev;
      logic     full;
      full = (entry_count >= CAPACITY);
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (full) begin
               queue_answer('0, STATUS_FULL, 1'b1);
            end else begin
               if (mode == MODE_PUSH_FRONT) link_front(v);
               else link_back(v);
               queue_answer(v, STATUS_OK, 1'b1);
            end
         end
         MODE_POP_FRONT: begin
            if (entry_count == 0) begin
               queue_answer('0, STATUS_EMPTY, 1'b1);
            end else begin
               s = head;
               queue_answer(slot_value[s], STATUS_OK, 1'b1);
               if (entry_count > 1) head = slot_link[s];
               free_slots[s] = 1'b1;
               entry_count--;
            end
         end
         MODE_POP_BACK: begin
            if (entry_count == 0) begin
               queue_answer('0, STATUS_EMPTY, 1'b1);
            end else begin
               s = tail;
               queue_answer(slot_value[s], STATUS_OK, 1'b1);
               if (entry_count > 1) begin
                  prev = walk_links(entry_count - 2);
                  slot_link[prev] = '0;
                  tail = prev;
               end
               free_slots[s] = 1'b1;
               entry_count--;
            end
         end
         MODE_INSERT: begin
            // Position is judged before fullness.
            if (int'(pos) > entry_count) begin
               queue_answer('0, STATUS_BADPOS, 1'b1);
            end else if (full) begin
               queue_answer('0, STATUS_FULL, 1'b1);
            end else begin
               if (pos == 0) begin
                  link_front(v);
               end else if (int'(pos) == entry_count) begin
                  link_back(v);
               end else begin
                  prev = walk_links(int'(pos) - 1);
                  s = claim_slot();
                  slot_value[s] = v;
                  slot_link[s] = slot_link[prev];
                  slot_link[prev] = s;
                  entry_count++;
               end
               queue_answer(v, STATUS_OK, 1'b1);
            end
         end
         MODE_DUMP: begin
            if (entry_count == 0) begin
               queue_answer('0, STATUS_EMPTY, 1'b1);
            end else begin
               s = head;
               for (int i = 0; i < entry_count; i++) begin
                  queue_answer(slot_value[s], STATUS_OK, i == entry_count - 1);
                  s = slot_link[s];
               end
            end
         end
         default: begin
            // Spare codes are dropped without an answer.
         end
      endcase
      if (entry_count > peak) peak = entry_count;
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns checker: %s", $time, msg);
   endfunction

   function automatic void check_result();
      list_answer_type want;
      if (answers.size() == 0) begin
         note_failure($sformatf("unexpected result: value %0d status %0d last %0b",
                                rsp_value_res, rsp_status, rsp_last));
         return;
      end
      want = answers[0];
      answers.delete(0);
      checked++;
      if (rsp_value_res !== want.value || rsp_status !== want.status ||
          rsp_last !== want.last)
         note_failure($sformatf(
            "result %0d: want value %0d status %0d last %0b, got %0d status %0d last %0b",
            checked, want.value, want.status, want.last,
            rsp_value_res, rsp_status, rsp_last));
   endfunction

   initial begin
      entry_count = 0;
      head = '0;
      tail = '0;
      free_slots = '1;
      mismatches = 0;
      accepted = 0;
      checked = 0;
      peak = 0;
      n_full = 0;
      n_empty = 0;
      n_badpos = 0;
   end

   // Results are checked before a new operation is taken in, so that a stray
   // result can never be matched against answers it does not belong to.
   always @(posedge clock) begin
      if (reset) begin
         answers.delete();
         entry_count = 0;
         head = '0;
         tail = '0;
         free_slots = '1;
      end else begin
         if (rsp_strobe) check_result();
         if (start && !busy) begin
            apply_operation(req_mode, req_value, req_position);
            accepted++;
         end
      end
      fail_count      <= mismatches;
      outstanding     <= answers.size();
      list_length     <= entry_count;
      ops_accepted    <= accepted;
      results_checked <= checked;
      peak_length     <= peak;
      full_hits       <= n_full;
      empty_hits      <= n_empty;
      badpos_hits     <= n_badpos;
   end

endmodule

// File: tb/bounded_linked_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded linked list engine: testbench top
// Drives list operations into the engine, directed corner cases first and then
// bursts of filling, draining, mixed traffic and dumps; the checker beside the engine
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine_tb;
   import blle_pkg::*;

   localparam int CAPACITY   = DEF_CAPACITY;
   localparam int RANDOM_OPS = 130;

   // Long enough for the longest busy stretch of the engine (pop back or insert
   // walking the whole list), with a little margin.
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

   // Mode codes the engine does not use; they must be dropped silently.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_ONES = -32'sd1;

   typedef enum logic [1:0] {
      BURST_FILL,
      BURST_DRAIN,
      BURST_MIXED,
      BURST_DUMP
   } burst_kind_type;

   // Every input is known from time zero; reset is high from the start.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_mode = MODE_PUSH_FRONT;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_position = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_value_res;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   int fail_count;
   int outstanding;
   int list_length;
   int ops_accepted;
   int results_checked;
   int peak_length;
   int full_hits;
   int empty_hits;
   int badpos_hits;

   // Operations sent so far, spare modes not counted.
   int ops_sent = 0;
   // Chance, in percent, that the sender leaves a gap before a transfer.
   int idle_percent = 13;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_linked_list_engine #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_strobe(rsp_strobe),
      .rsp_value_res(rsp_value_res),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   blle_checker #(
      .CAPACITY(CAPACITY)
   ) list_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_strobe(rsp_strobe),
      .rsp_value_res(rsp_value_res),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .list_length(list_length),
      .ops_accepted(ops_accepted),
      .results_checked(results_checked),
      .peak_length(peak_length),
      .full_hits(full_hits),
      .empty_hits(empty_hits),
      .badpos_hits(badpos_hits)
   );

   // Mostly random words, with the extremes turning up now and then.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 15))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return VALUE_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Insert positions are mostly legal for the present length; some point one
   // past the end, and some are anywhere in the 8-bit range.
   function automatic logic [7:0] pick_position(int len);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 8'($urandom_range(0, len));
      if (roll < 85) return 8'(len + 1);
      return 8'($urandom_range(0, 255));
   endfunction

   // Brings the sender to the falling edge at which the next transfer is
   // offered, leaving an occasional gap first. During a gap the request
   // fields wander, so that the engine is seen to ignore them.
   task automatic slot_wait();
      int gap;
      if (idle_percent > 0 && $urandom_range(0, 99) < idle_percent) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start        <= 1'b0;
            req_mode     <= 3'($urandom);
            req_value    <= $urandom;
            req_position <= 8'($urandom);
         end
      end
      @(negedge clock);
   endtask

   // Offers one operation and holds it until the engine takes it. Start is
   // left high, so that a following call at the next falling edge gives a
   // back-to-back transfer.
   task automatic issue(input logic [2:0] mode, input logic signed [31:0] val,
                        input logic [7:0] pos);
      start        <= 1'b1;
      req_mode     <= mode;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (busy);
      if (mode <= MODE_DUMP) ops_sent++;
   endtask

   task automatic send(input logic [2:0] mode, input logic signed [31:0] val,
                       input logic [7:0] pos);
      slot_wait();
      issue(mode, val, pos);
   endtask

   // Holds the sender off until every answer has come back and the engine
   // has gone idle.
   task automatic wait_all_answered();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   // One burst of related traffic. The list length is read at the falling
   // edge, when the checker has already taken in the previous transfer.
   task automatic run_burst(burst_kind_type kind);
      int         spare;
      int         count;
      logic [2:0] mode;
      case (kind)
         BURST_FILL: begin
            // Grow the list until it is full, then knock on the door once or
            // twice more to see the full status.
            spare = $urandom_range(1, 2);
            while (spare > 0) begin
               slot_wait();
               if (list_length >= CAPACITY) spare--;
               case ($urandom_range(0, 2))
                  0: mode = MODE_PUSH_FRONT;
                  1: mode = MODE_PUSH_BACK;
                  default: mode = MODE_INSERT;
               endcase
               issue(mode, pick_value(), pick_position(list_length));
            end
         end
         BURST_DRAIN: begin
            // Pop from either end until the list is empty and then a little
            // further, with the odd dump along the way.
            spare = $urandom_range(1, 2);
            while (spare > 0) begin
               slot_wait();
               if (list_length == 0) spare--;
               if ($urandom_range(0, 9) == 0) mode = MODE_DUMP;
               else if ($urandom_range(0, 1) != 0) mode = MODE_POP_FRONT;
               else mode = MODE_POP_BACK;
               issue(mode, pick_value(), pick_position(list_length));
            end
         end
         BURST_MIXED: begin
            count = $urandom_range(4, 12);
            repeat (count) begin
               slot_wait();
               if ($urandom_range(0, 99) < 4)
                  mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
               else
                  mode = 3'($urandom_range(MODE_PUSH_FRONT, MODE_DUMP));
               issue(mode, pick_value(), pick_position(list_length));
            end
         end
         default: begin
            send(MODE_DUMP, pick_value(), 8'($urandom));
         end
      endcase
   endtask

   // Stimulus and verdict.
   initial begin
      int             directed_ops;
      int             roll;
      bit             paused;
      burst_kind_type kind;

      paused = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Operations on the empty list come first: both pops,
      // the empty dump and an insert past the end.
      send(MODE_POP_FRONT, VALUE_ONES, 8'd0);
      send(MODE_POP_BACK, VALUE_ONES, 8'd0);
      send(MODE_DUMP, '0, 8'd0);
      send(MODE_INSERT, VALUE_MAX, 8'd1);
      // Insert at the head of an empty list, then both pushes at the
      // extremes of the value range.
      send(MODE_INSERT, VALUE_MAX, 8'd0);
      send(MODE_PUSH_BACK, VALUE_MIN, 8'd0);
      send(MODE_PUSH_FRONT, VALUE_ONES, 8'd255);
      // An insert at the length lands at the tail; the next one goes into
      // the middle and needs a walk.
      send(MODE_INSERT, '0, 8'd3);
      send(MODE_INSERT, 32'sh5a5a_a5a5, 8'd2);
      send(MODE_INSERT, 32'sh1234_5678, 8'd255);
      // Spare mode codes must give no result at all.
      send(MODE_SPARE_A, VALUE_ONES, 8'd255);
      send(MODE_SPARE_B, VALUE_MIN, 8'd170);
      send(MODE_DUMP, '0, 8'd85);
      // Take the list apart from both ends, down to empty and beyond, so
      // that the head and tail kept across an empty list are exercised.
      send(MODE_POP_BACK, '0, 8'd0);
      send(MODE_POP_FRONT, '0, 8'd0);
      send(MODE_POP_BACK, '0, 8'd0);
      send(MODE_POP_FRONT, '0, 8'd0);
      send(MODE_POP_BACK, '0, 8'd0);
      send(MODE_POP_FRONT, '0, 8'd0);
      send(MODE_PUSH_BACK, 32'sh0f0f_0f0f, 8'd0);
      send(MODE_PUSH_FRONT, 32'sh0000_0001, 8'd0);
      send(MODE_DUMP, '0, 8'd0);
      send(MODE_POP_BACK, '0, 8'd0);
      send(MODE_DUMP, '0, 8'd0);
      wait_all_answered();
      directed_ops = ops_sent;

      // Random part. It opens with a fill and a drain so that the full list
      // is reached early, then mixes bursts at random.
      run_burst(BURST_FILL);
      run_burst(BURST_DRAIN);
      while (ops_sent < directed_ops + RANDOM_OPS) begin
         // A long stretch in the middle runs with no gaps at all.
         if (ops_sent >= directed_ops + 50 && ops_sent < directed_ops + 100)
            idle_percent = 0;
         else
            idle_percent = 13;
         // Once, half way, the sender waits for the engine to drain fully.
         if (!paused && ops_sent >= directed_ops + RANDOM_OPS / 2) begin
            wait_all_answered();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 25) kind = BURST_FILL;
         else if (roll < 45) kind = BURST_DRAIN;
         else if (roll < 90) kind = BURST_MIXED;
         else kind = BURST_DUMP;
         run_burst(kind);
      end

      // Let everything come back, then watch a while longer for stray
      // results before the verdict.
      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("Run covered %0d operations and %0d checked results; list peaked at %0d of %0d.",
               ops_accepted, results_checked, peak_length, CAPACITY);
      $display("Answers seen: %0d full, %0d empty, %0d bad position; %0d mismatches.",
               full_hits, empty_hits, badpos_hits, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Run timed out with %0d results still expected.", outstanding);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
